### rtl/mlet_pkg.sv
package mlet_pkg;

   localparam int MAX_LABELS = 16;
   localparam int ADDR_W     = $clog2(MAX_LABELS);
   localparam int CNT_W      = $clog2(MAX_LABELS + 1);
   localparam int TIME_W     = 31;
   localparam int VALUE_W    = 32;
   localparam int CMD_W      = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_START  = 3'd1,
      CMD_STOP   = 3'd2,
      CMD_SET    = 3'd3,
      CMD_READ   = 3'd4,
      CMD_APPEND = 3'd5,
      CMD_CLEAR  = 3'd6
   } cmd_type;

   // label table write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] data;
   } ram_wr_type;

   // one result transaction
   typedef struct packed {
      logic              fired;
      logic [ADDR_W-1:0] label_index;
      logic [TIME_W-1:0] label_time;
      logic [TIME_W-1:0] count_now;
      logic              is_active;
      logic              is_running;
      logic [CNT_W-1:0]  labels_held;
      logic              accepted;
   } rsp_type;

endpackage

### rtl/mlet_label_ram.sv
module mlet_label_ram
   import mlet_pkg::*;
(
   input  logic              clock,
   input  ram_wr_type        wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [TIME_W-1:0] rd_data
);

   logic [TIME_W-1:0] mem [MAX_LABELS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/mlet_ctrl.sv
module mlet_ctrl
   import mlet_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               slot_free,
   output logic               rsp_load,
   output rsp_type            rsp_data,
   output ram_wr_type         ram_wr,
   output logic [ADDR_W-1:0]  ram_rd_addr,
   input  logic [TIME_W-1:0]  ram_rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WALK
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [TIME_W-1:0]   target_ff, target_in;
   logic [CNT_W-1:0]    walk_idx_ff, walk_idx_in;
   logic [TIME_W-1:0]   base_ff, base_in;
   logic [TIME_W-1:0]   count_ff, count_in;
   logic                active_ff, active_in;
   logic                running_ff, running_in;
   logic [CNT_W-1:0]    next_ff, next_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [TIME_W-1:0]   last_ff, last_in;

   logic [TIME_W-1:0]   raw_time;
   logic                raw_neg;
   logic [TIME_W-1:0]   clamped;
   logic [TIME_W-1:0]   count_inc;
   logic [CNT_W-1:0]    next_inc;
   logic [CNT_W-1:0]    walk_inc;
   logic [CNT_W-1:0]    found_idx;
   logic                walk_hit;

   assign raw_neg   = value_ff[VALUE_W-1];
   assign raw_time  = value_ff[TIME_W-1:0];
   assign clamped   = raw_neg ? '0 : ((raw_time > last_ff) ? last_ff : raw_time);
   assign count_inc = count_ff + TIME_W'(1);
   assign next_inc  = next_ff + CNT_W'(1);
   assign walk_inc  = walk_idx_ff + CNT_W'(1);
   assign walk_hit  = ram_rd_data > target_ff;
   assign found_idx = walk_hit ? walk_idx_ff : total_ff;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      value_in    = value_ff;
      target_in   = target_ff;
      walk_idx_in = walk_idx_ff;
      base_in     = base_ff;
      count_in    = count_ff;
      active_in   = active_ff;
      running_in  = running_ff;
      next_in     = next_ff;
      total_in    = total_ff;
      last_in     = last_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      ram_wr      = '0;
      rsp_data    = '0;
      rsp_data.accepted = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = slot_free;
            if (req_valid && slot_free) begin
               cmd_in   = cmd_type'(req_cmd);
               value_in = req_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            rsp_load = 1'b1;
            unique case (cmd_ff)
               CMD_TICK: begin
                  if (running_ff && (next_ff < total_ff)) begin
                     // zero interval fires without advancing the count
                     if ((count_ff >= ram_rd_data) || (count_inc == ram_rd_data)) begin
                        rsp_data.fired       = 1'b1;
                        rsp_data.label_index = next_ff[ADDR_W-1:0];
                        rsp_data.label_time  = ram_rd_data;
                        base_in    = ram_rd_data;
                        count_in   = ram_rd_data;
                        next_in    = next_inc;
                        running_in = next_inc < total_ff;
                     end else begin
                        count_in = count_inc;
                     end
                  end else begin
                     running_in = 1'b0;
                  end
               end
               CMD_START: begin
                  if (!active_ff) begin
                     active_in = 1'b1;
                     if ((total_ff != '0) && (base_ff < last_ff) && (next_ff < total_ff)) begin
                        running_in = 1'b1;
                        count_in   = base_ff;
                     end
                  end
               end
               CMD_STOP: begin
                  if (active_ff) begin
                     active_in = 1'b0;
                     if (running_ff) begin
                        base_in    = count_ff;
                        running_in = 1'b0;
                     end
                  end
               end
               CMD_SET: begin
                  // a value equal to the stored base is ignored
                  if ((total_ff != '0) && (clamped != base_ff)) begin
                     target_in   = clamped;
                     walk_idx_in = '0;
                     state_in    = S_WALK;
                     rsp_load    = 1'b0;
                  end
               end
               CMD_APPEND: begin
                  if ((total_ff >= CNT_W'(MAX_LABELS)) || raw_neg ||
                      ((total_ff != '0) && (raw_time <= last_ff))) begin
                     rsp_data.accepted = 1'b0;
                  end else begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = total_ff[ADDR_W-1:0];
                     ram_wr.data = raw_time;
                     total_in    = total_ff + CNT_W'(1);
                     last_in     = raw_time;
                  end
               end
               CMD_CLEAR: begin
                  running_in = 1'b0;
                  active_in  = 1'b0;
                  total_in   = '0;
                  next_in    = '0;
                  base_in    = '0;
                  count_in   = '0;
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            // first label above the new base, or the table length if none
            if (walk_hit || (walk_inc == total_ff)) begin
               base_in    = target_ff;
               count_in   = target_ff;
               next_in    = found_idx;
               running_in = active_ff && (target_ff < last_ff) && (found_idx < total_ff);
               rsp_load   = 1'b1;
               state_in   = S_IDLE;
            end else begin
               walk_idx_in = walk_inc;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_data.count_now   = count_in;
      rsp_data.is_active   = active_in;
      rsp_data.is_running  = running_in;
      rsp_data.labels_held = total_in;

      // pending label on entry, walk position otherwise
      ram_rd_addr = (state_ff == S_IDLE) ? next_ff[ADDR_W-1:0] : walk_idx_in[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         base_ff    <= '0;
         count_ff   <= '0;
         active_ff  <= 1'b0;
         running_ff <= 1'b0;
         next_ff    <= '0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         base_ff    <= base_in;
         count_ff   <= count_in;
         active_ff  <= active_in;
         running_ff <= running_in;
         next_ff    <= next_in;
         total_ff   <= total_in;
      end
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      target_ff   <= target_in;
      walk_idx_ff <= walk_idx_in;
      last_ff     <= last_in;
   end

endmodule

### rtl/multi_label_elapsed_timer.sv
// flow: a request is registered into the exec state, and its result into the response slot;
// a set that moves the base first scans the label table in the walk state
// requests are taken only in the idle state while the response slot is free, so a new
// request waits for the last; a set that moves the base holds requests off while it scans
// reset: synchronous active-high, clears count, flags and label count; the label
// ram is not cleared, only entries below the label count are ever used
module multi_label_elapsed_timer
   import mlet_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_fired,
   output logic [ADDR_W-1:0]         rsp_label_index,
   output logic [TIME_W-1:0]         rsp_label_time,
   output logic [TIME_W-1:0]         rsp_count_now,
   output logic                      rsp_is_active,
   output logic                      rsp_is_running,
   output logic [CNT_W-1:0]          rsp_labels_held,
   output logic                      rsp_accepted
);

   // label table storage
   ram_wr_type        ram_wr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [TIME_W-1:0] ram_rd_data;

   // response slot
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_load;
   rsp_type           rsp_new;
   logic              slot_free;

   // the slot can take a new result when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   mlet_label_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // command sequencer: reads the pending label, walks the table on a set
   mlet_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_value   (req_value),
      .slot_free   (slot_free),
      .rsp_load    (rsp_load),
      .rsp_data    (rsp_new),
      .ram_wr      (ram_wr),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_new;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // response transaction fields
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired       = rsp_ff.fired;
   assign rsp_label_index = rsp_ff.label_index;
   assign rsp_label_time  = rsp_ff.label_time;
   assign rsp_count_now   = rsp_ff.count_now;
   assign rsp_is_active   = rsp_ff.is_active;
   assign rsp_is_running  = rsp_ff.is_running;
   assign rsp_labels_held = rsp_ff.labels_held;
   assign rsp_accepted    = rsp_ff.accepted;

endmodule
